// ===== rtl/bb3_pkg.sv =====
// Shared types and constants for the 3x3 clipped box blur.
// Used by the controller, datapath, divider and top level; no dependencies.
package bb3_pkg;

   localparam int PIX_W          = 8;
   localparam int CHAN_N         = 3;
   localparam int PIXEL_W        = PIX_W * CHAN_N;
   localparam int WIN_N          = 9;
   localparam int DIM_W          = 11;
   localparam int SUM_W          = 12;
   localparam int NCNT_W         = 4;
   localparam int NUM_W          = 13;
   localparam int DEN_W          = 5;
   localparam int QUO_W          = 8;
   localparam int STEP_W         = 4;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

   typedef logic [0:0] reg_idx_type;
   localparam reg_idx_type REG_IMAGE_WIDTH  = 1'b0;
   localparam reg_idx_type REG_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic shift;
      logic sum_load;
      logic div_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic div_idle;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/box_blur_3x3_clipped_top.sv =====
// Top level of the 3x3 clipped box blur: register port, controller, datapath.
// Depends on bb3_pkg, bb3_ctrl, bb3_dp.
//
//   port group  direction  payload
//   req_*       in         tdata = blue_in, green_in, red_in
//   rsp_*       out        tdata = blue_out, green_out, red_out; tlast = frame_end
//   csr_*       in/out     image_width @ 0x0, image_height @ 0x4
//
// An item with no result passes through accept and row store update; an item
// with a result passes through accept, row store update, neighborhood sum,
// divider load, 8 divider steps, divider done and output load.
// Reset is synchronous: size returns to 640x480, counters and window clear;
// row stores are not cleared. A finished result waits in the output register
// while the next item is accepted and worked on; a full output register holds
// the controller in its emit state.
module box_blur_3x3_clipped_top import bb3_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,   // blue_in, green_in, red_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_W-1:0]    rsp_tdata,   // blue_out, green_out, red_out
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   reg_idx_type      reg_idx;
   logic             csr_write;
   cmd_type          cmd;
   status_type       sts;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_IMAGE_WIDTH:  width_in  = csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_pwdata[DIM_W-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   bb3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .cmd        (cmd)
   );

   bb3_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = cmd.take;

endmodule

// ===== rtl/bb3_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bb3_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, for one channel.
// Depends on bb3_pkg.
module bb3_div import bb3_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [QUO_W-1:0] quo
);

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  dsh_ff, dsh_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              ge;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = num;
         dsh_in  = NUM_W'({den, {(QUO_W-1){1'b0}}});
         quo_in  = '0;
         cnt_in  = STEP_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? (rem_ff - dsh_ff) : rem_ff;
         quo_in  = {quo_ff[QUO_W-2:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - STEP_W'(1);
         busy_in = (cnt_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/bb3_ctrl.sv =====
// Controller state machine: sequences accept, row update, sum, divide, emit.
// Depends on bb3_pkg.
module bb3_ctrl import bb3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = sts.emit ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_idle) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:      cmd.take      = 1'b1;
         ST_UPDATE:    cmd.shift     = 1'b1;
         ST_SUM:       cmd.sum_load  = 1'b1;
         ST_DIV_START: cmd.div_start = 1'b1;
         ST_EMIT:      cmd.out_load  = sts.out_free;
         default:      cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_update_follows_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> $past(state_ff == ST_IDLE && req_tvalid))
      else $error("row update without an accepted item");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !sts.out_free) |=> state_ff == ST_EMIT)
      else $error("result dropped while output register busy");

endmodule

// ===== rtl/bb3_dp.sv =====
// Datapath: position counters, row stores, 3x3 window, clipped sums,
// dividers and output register. Depends on bb3_pkg, bb3_ram, bb3_div.
module bb3_dp import bb3_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         sts,
   input  logic               req_tvalid,
   input  logic [PIXEL_W-1:0] req_tdata,
   input  logic [DIM_W-1:0]   cfg_width,
   input  logic [DIM_W-1:0]   cfg_height,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [PIXEL_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ORW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CX_W  = COL_W + 1;
   localparam int RX_W  = ORW_W + 1;
   localparam int WX_W  = (DIM_W > CX_W) ? DIM_W : CX_W;
   localparam int HX_W  = (DIM_W > RX_W) ? DIM_W : RX_W;

   logic              accept;
   logic [WX_W-1:0]   w_ext, w_clamp;
   logic [HX_W-1:0]   h_ext, h_clamp;
   logic [CX_W-1:0]   w_eff, in_col_x, ocol_x;
   logic [RX_W-1:0]   h_eff, orow_x;
   logic              col_last, pix_ok, emit, last, ocol_last;
   logic [2:0]        rv, cv;

   logic [COL_W-1:0]   in_col_ff, in_col_in;
   logic [RX_W-1:0]    in_row_ff, in_row_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [ORW_W-1:0]   out_row_ff, out_row_in;
   logic [PIXEL_W-1:0] x_ff, x_in;
   logic [PIXEL_W-1:0] win_ff [WIN_N];
   logic [PIXEL_W-1:0] win_in [WIN_N];
   logic [PIXEL_W-1:0] upper_rdata, middle_rdata;

   logic [SUM_W-1:0]   sum_c [CHAN_N];
   logic [NCNT_W-1:0]  n_c;
   logic [SUM_W-1:0]   sum_ff [CHAN_N];
   logic [SUM_W-1:0]   sum_in [CHAN_N];
   logic [NCNT_W-1:0]  n_ff, n_in;
   logic               last_ff, last_in;

   logic [CHAN_N-1:0]  div_busy;
   logic [QUO_W-1:0]   quo [CHAN_N];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   assign accept = cmd.take & req_tvalid;

   // effective frame size: zero acts as one, large values saturate
   assign w_ext   = WX_W'(cfg_width);
   assign w_clamp = (w_ext == '0) ? WX_W'(1) :
                    (w_ext > WX_W'(MAX_WIDTH)) ? WX_W'(MAX_WIDTH) : w_ext;
   assign w_eff   = CX_W'(w_clamp);
   assign h_ext   = HX_W'(cfg_height);
   assign h_clamp = (h_ext == '0) ? HX_W'(1) :
                    (h_ext > HX_W'(MAX_HEIGHT)) ? HX_W'(MAX_HEIGHT) : h_ext;
   assign h_eff   = RX_W'(h_clamp);

   assign in_col_x = {1'b0, in_col_ff};
   assign col_last = (in_col_x + CX_W'(1)) >= w_eff;
   assign pix_ok   = in_row_ff < h_eff;
   assign emit     = (in_row_ff > RX_W'(1)) ||
                     ((in_row_ff == RX_W'(1)) && (in_col_ff != '0));

   assign orow_x = {1'b0, out_row_ff};
   assign ocol_x = {1'b0, out_col_ff};
   assign rv[0]  = (orow_x != '0) && (orow_x <= h_eff);
   assign rv[1]  = orow_x < h_eff;
   assign rv[2]  = (orow_x + RX_W'(1)) < h_eff;
   assign cv[0]  = (ocol_x != '0) && (ocol_x <= w_eff);
   assign cv[1]  = ocol_x < w_eff;
   assign cv[2]  = (ocol_x + CX_W'(1)) < w_eff;
   assign last   = (orow_x >= (h_eff - RX_W'(1))) && (ocol_x >= (w_eff - CX_W'(1)));
   assign ocol_last = (ocol_x + CX_W'(1)) >= w_eff;

   bb3_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock (clock),
      .we    (cmd.shift),
      .addr  (in_col_ff),
      .wdata (middle_rdata),
      .rdata (upper_rdata)
   );

   bb3_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock (clock),
      .we    (cmd.shift),
      .addr  (in_col_ff),
      .wdata (x_ff),
      .rdata (middle_rdata)
   );

   // clipped neighborhood sums
   always_comb begin
      n_c = '0;
      for (int ch = 0; ch < CHAN_N; ch++) begin
         sum_c[ch] = '0;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (rv[r] && cv[c]) begin
               n_c = n_c + NCNT_W'(1);
               for (int ch = 0; ch < CHAN_N; ch++) begin
                  sum_c[ch] = sum_c[ch] + SUM_W'(win_ff[r*3+c][ch*PIX_W +: PIX_W]);
               end
            end
         end
      end
   end

   always_comb begin
      x_in       = x_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      n_in       = n_ff;
      last_in    = last_ff;
      for (int i = 0; i < WIN_N; i++) begin
         win_in[i] = win_ff[i];
      end
      for (int ch = 0; ch < CHAN_N; ch++) begin
         sum_in[ch] = sum_ff[ch];
      end

      if (accept) begin
         x_in = pix_ok ? req_tdata : '0;
      end

      if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r*3]   = win_ff[r*3+1];
            win_in[r*3+1] = win_ff[r*3+2];
         end
         win_in[2] = upper_rdata;
         win_in[5] = middle_rdata;
         win_in[8] = x_ff;
         if (col_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RX_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end

      if (cmd.sum_load) begin
         n_in    = n_c;
         last_in = last;
         for (int ch = 0; ch < CHAN_N; ch++) begin
            sum_in[ch] = sum_c[ch];
         end
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (ocol_last) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ORW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   for (genvar ch = 0; ch < CHAN_N; ch++) begin : g_div
      bb3_div u_div (
         .clock (clock),
         .reset (reset),
         .start (cmd.div_start),
         .num   (NUM_W'({sum_ff[ch], 1'b0}) + NUM_W'(n_ff)),
         .den   ({n_ff, 1'b0}),
         .busy  (div_busy[ch]),
         .quo   (quo[ch])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = last_ff;
         for (int ch = 0; ch < CHAN_N; ch++) begin
            rsp_data_in[ch*PIX_W +: PIX_W] = (n_ff == '0) ? '0 : quo[ch];
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WIN_N; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < WIN_N; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
      x_ff        <= x_in;
      n_ff        <= n_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      for (int ch = 0; ch < CHAN_N; ch++) begin
         sum_ff[ch] <= sum_in[ch];
      end
   end

   assign sts.emit     = emit;
   assign sts.div_idle = ~|div_busy;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten");

   a_div_done_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> ~|div_busy)
      else $error("result loaded before divide finished");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_load |=> n_ff <= NCNT_W'(WIN_N))
      else $error("neighbor count out of range");

endmodule

// ===== sim/bb3_blur_checker.sv =====
// Scoreboard for the 3x3 clipped box blur: watches the item, result and register
// ports, predicts each blurred pixel and compares it field by field.
// Depends on bb3_pkg.
module bb3_blur_checker import bb3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,   // blue_in, green_in, red_in
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [PIXEL_W-1:0]    rsp_tdata,   // blue_out, green_out, red_out
   input  logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    results_pending
);

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             frame_end;
   } blurred_pixel_type;

   blurred_pixel_type  pending_pixels[$];
   logic [PIXEL_W-1:0] upper_line[DEF_MAX_WIDTH];
   logic [PIXEL_W-1:0] middle_line[DEF_MAX_WIDTH];
   logic [PIXEL_W-1:0] window[WIN_N];
   logic [DIM_W-1:0]   width_reg;
   logic [DIM_W-1:0]   height_reg;
   int                 in_row, in_col, out_row, out_col;
   int                 errors;

   function automatic int clip_dim(logic [DIM_W-1:0] v, int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return int'(v);
   endfunction

   function automatic logic [PIX_W-1:0] round_mean(int total, int count);
      if (count == 0) return '0;
      return PIX_W'((2 * total + count) / (2 * count));
   endfunction

   task automatic note(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
   endtask

   // one accepted item: advance the delay lines and window, maybe emit a pixel
   task automatic blur_step(input logic [PIXEL_W-1:0] pixel);
      int w, h, col, count, r, c;
      int total[CHAN_N];
      logic [PIXEL_W-1:0] fresh, up, mid, p;
      logic emit;
      blurred_pixel_type res;
      w = clip_dim(width_reg, DEF_MAX_WIDTH);
      h = clip_dim(height_reg, DEF_MAX_HEIGHT);
      col = in_col % DEF_MAX_WIDTH;
      emit = in_row > 1 || (in_row == 1 && col >= 1);
      fresh = (in_row < h) ? pixel : '0;   // drain items feed zero
      up = upper_line[col];
      mid = middle_line[col];
      upper_line[col] = mid;
      middle_line[col] = fresh;
      for (int k = 0; k < 3; k++) begin
         window[3*k]   = window[3*k+1];
         window[3*k+1] = window[3*k+2];
      end
      window[2] = up;
      window[5] = mid;
      window[8] = fresh;
      if (col + 1 >= w) begin
         in_col = 0;
         in_row = (in_row + 1) & 'h7FF;
      end else begin
         in_col = col + 1;
      end
      if (emit) begin
         total = '{default: 0};
         count = 0;
         for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
               r = out_row + dr;
               c = out_col + dc;
               if (r >= 0 && r < h && c >= 0 && c < w) begin
                  p = window[(dr + 1) * 3 + dc + 1];
                  total[0] += int'(p[7:0]);
                  total[1] += int'(p[15:8]);
                  total[2] += int'(p[23:16]);
                  count++;
               end
            end
         end
         res.blue = round_mean(total[0], count);
         res.green = round_mean(total[1], count);
         res.red = round_mean(total[2], count);
         res.frame_end = out_row >= h - 1 && out_col >= w - 1;
         pending_pixels.push_back(res);
         if (res.frame_end) begin
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
         end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1) & 'h3FF;
         end else begin
            out_col = (out_col + 1) & 'h3FF;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      blurred_pixel_type got, want;
      reg_idx_type idx;
      logic [CSR_DATA_W-1:0] reg_value;
      if (reset) begin
         width_reg = WIDTH_RST;
         height_reg = HEIGHT_RST;
         for (int k = 0; k < DEF_MAX_WIDTH; k++) begin
            upper_line[k] = '0;
            middle_line[k] = '0;
         end
         for (int k = 0; k < WIN_N; k++) window[k] = '0;
         in_row = 0;
         in_col = 0;
         out_row = 0;
         out_col = 0;
         errors = 0;
         pending_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tlast};
            if (pending_pixels.size() == 0) begin
               note("unexpected result", '0, 32'({rsp_tlast, rsp_tdata}));
            end else begin
               want = pending_pixels.pop_front();
               if (got.blue !== want.blue)
                  note("blue_out", 32'(want.blue), 32'(got.blue));
               if (got.green !== want.green)
                  note("green_out", 32'(want.green), 32'(got.green));
               if (got.red !== want.red)
                  note("red_out", 32'(want.red), 32'(got.red));
               if (got.frame_end !== want.frame_end)
                  note("frame_end", 32'(want.frame_end), 32'(got.frame_end));
            end
         end
         if (req_tvalid && req_tready) blur_step(req_tdata);
         if (csr_psel && csr_penable && csr_pready) begin
            idx = reg_idx_type'(csr_paddr >> 2);
            if (csr_pwrite) begin
               if (idx == REG_IMAGE_WIDTH) width_reg = csr_pwdata[DIM_W-1:0];
               else height_reg = csr_pwdata[DIM_W-1:0];
            end else begin
               reg_value = (idx == REG_IMAGE_WIDTH) ? CSR_DATA_W'(width_reg)
                                                    : CSR_DATA_W'(height_reg);
               if (csr_prdata !== reg_value) note("register read", reg_value, csr_prdata);
            end
         end
      end
      mismatch_count <= errors;
      results_pending <= pending_pixels.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the 3x3 clipped box blur: clock, reset, register setup,
// bursty pixel frames and a stalling result sink; verdict from bb3_blur_checker.
// Depends on bb3_pkg, box_blur_3x3_clipped_top, bb3_blur_checker.
module tb import bb3_pkg::*; ();

   typedef enum {PIX_NOISE, PIX_RAIL, PIX_WHITE} pixel_mix_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    results_pending;

   logic [DIM_W-1:0] width_now = WIDTH_RST;
   logic [DIM_W-1:0] height_now = HEIGHT_RST;
   int frame_w, frame_h, items_sent, burst_left;
   int rx_left;
   bit valid_up, steady, rx_stalling;

   box_blur_3x3_clipped_top DUT (.*);
   bb3_blur_checker u_blur_check (.*);

   always #5 clock = ~clock;

   // result sink: alternating ready runs and stalls, some stalls past a full pixel
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_stalling = !rx_stalling;
         if (rx_stalling)
            rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 30)
                                                  : $urandom_range(1, 9);
         else
            rx_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 12);
      end
      rx_left--;
      rsp_tready <= !rx_stalling;
   end

   function automatic int fit_dim(logic [DIM_W-1:0] v, int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return int'(v);
   endfunction

   function automatic logic [PIXEL_W-1:0] make_pixel(pixel_mix_type mix);
      logic [PIXEL_W-1:0] px;
      px = PIXEL_W'($urandom());
      if (mix == PIX_WHITE) px = '1;
      if (mix == PIX_RAIL) begin
         px[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return px;
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim(int span);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick < 14) return DIM_W'($urandom_range(1, 6));
      if (pick < 18) return DIM_W'($urandom_range(1, span));
      return DIM_W'($urandom_range(1, 4 * span));
   endfunction

   task automatic stop_input();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 0;
      end
   endtask

   task automatic send_item(input logic [PIXEL_W-1:0] data);
      req_tdata <= data;
      if (!valid_up) begin
         req_tvalid <= 1'b1;
         valid_up = 1;
      end
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (!steady) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            stop_input();
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic send_frame(input pixel_mix_type mix);
      for (int k = 0; k < frame_w * frame_h; k++) send_item(make_pixel(mix));
      for (int k = 0; k <= frame_w; k++) send_item(PIXEL_W'($urandom()));
   endtask

   // psel stays up between back-to-back accesses; caller drops it afterwards
   task automatic csr_access(input bit write, input reg_idx_type idx,
                             input logic [DIM_W-1:0] value);
      csr_paddr <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata <= ($urandom() & 32'hFFFF_F800) | CSR_DATA_W'(value);
      csr_pwrite <= write;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic set_frame(input bit write_w, input logic [DIM_W-1:0] new_w,
                            input bit write_h, input logic [DIM_W-1:0] new_h);
      stop_input();
      do @(posedge clock); while (results_pending != 0);
      repeat (20) @(posedge clock);
      if (write_w) begin
         csr_access(1'b1, REG_IMAGE_WIDTH, new_w);
         width_now = new_w;
      end
      if (write_h) begin
         csr_access(1'b1, REG_IMAGE_HEIGHT, new_h);
         height_now = new_h;
      end
      csr_access(1'b0, REG_IMAGE_WIDTH, '0);
      csr_access(1'b0, REG_IMAGE_HEIGHT, '0);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      frame_w = fit_dim(width_now, DEF_MAX_WIDTH);
      frame_h = fit_dim(height_now, DEF_MAX_HEIGHT);
   endtask

   initial begin : stimulus
      bit write_w;
      pixel_mix_type mix;
      burst_left = $urandom_range(1, 24);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset values, then small frames with rail, white and noise pixels
      set_frame(0, '0, 0, '0);
      set_frame(1, 11'd3, 1, 11'd3);
      send_frame(PIX_RAIL);
      set_frame(1, 11'd2, 1, 11'd2);
      send_frame(PIX_WHITE);
      set_frame(1, 11'd1, 1, 11'd1);
      send_frame(PIX_NOISE);

      // zero width acts as one, oversized height saturates
      steady = 1;
      set_frame(1, 11'd0, 1, 11'd2047);
      send_frame(PIX_NOISE);
      steady = 0;

      set_frame(1, pick_dim(16), 1, pick_dim(4));
      while (items_sent < 1550) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) < 2) begin
            write_w = ($urandom_range(0, 3) != 0);
            set_frame(write_w, pick_dim(16), !write_w || $urandom_range(0, 3) != 0,
                      pick_dim(4));
         end
         if ($urandom_range(0, 7) == 0) mix = PIX_WHITE;
         else if ($urandom_range(0, 3) == 0) mix = PIX_RAIL;
         else mix = PIX_NOISE;
         send_frame(mix);
      end

      stop_input();
      do @(posedge clock); while (results_pending != 0);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
